>>> rtl/core/sftdb_pkg.sv
// Package for the sfnt table directory builder.
// Holds payload structs, result and state codes, control/status structs and a helper.
// No dependencies.
package sftdb_pkg;

   localparam logic [31:0] VER_TRUETYPE = 32'h0001_0000;
   localparam logic [31:0] TAG_CFF      = 32'h4346_4620;
   localparam logic [31:0] TAG_OTTO     = 32'h4F54_544F;

   typedef enum logic [1:0] {
      KIND_HEADER    = 2'd0,
      KIND_ENTRY     = 2'd1,
      KIND_ERR_COUNT = 2'd2,
      KIND_ERR_SIZE  = 2'd3
   } result_kind_type;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_HEADER,
      ST_FETCH,
      ST_DATA
   } state_type;

   typedef struct packed {
      logic        req_type;
      logic [31:0] table_tag;
      logic [31:0] table_length;
      logic [31:0] data_word;
      logic        last_table;
   } req_payload_type;

   typedef struct packed {
      result_kind_type result_kind;
      logic [31:0]     sfnt_version;
      logic [6:0]      table_count;
      logic [15:0]     search_range;
      logic [3:0]      entry_selector;
      logic [15:0]     range_shift;
      logic [26:0]     total_size;
      logic [31:0]     entry_tag;
      logic [31:0]     entry_checksum;
      logic [26:0]     entry_offset;
      logic [26:0]     entry_length;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic            info_wr;
      logic            hdr_start;
      logic            word_acc;
      logic            entry_emit;
      logic            clear;
      logic            rsp_load;
      result_kind_type rsp_kind;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_over;
      logic size_over;
      logic word_last;
      logic table_last;
   } dp_status_type;

   // round a byte count up to a multiple of four
   function automatic logic [27:0] pad4(input logic [26:0] n);
      return ({1'b0, n} + 28'd3) & ~28'd3;
   endfunction

endpackage

>>> rtl/core/sftdb_chan_if.sv
// Valid/ready channel interface used for request and response transactions.
// Depends on sftdb_pkg only through the payload type given at instantiation.
interface sftdb_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/sfnt_table_directory_builder_core.sv
// Info items: one per cycle unless the output stalls; the header or error result
// follows the last info item: ST_HEADER forms it once the output register is free.
// Data words: one per cycle within a table unless the output stalls; a table's entry
// leaves the cycle after its final word; a table start reads the store in ST_FETCH.
// Synchronous active-high reset clears all control state; the table store has no
// reset and needs no clearing pass.
module sfnt_table_directory_builder_core #(
   parameter int MAX_TABLES = 64,
   parameter int SIZE_LIMIT = 67108864
) (
   input logic         clock,
   input logic         reset,
   sftdb_chan_if.sink   req_chan,
   sftdb_chan_if.source rsp_chan
);

   sftdb_pkg::ctl_cmd_type     cmd;
   sftdb_pkg::dp_status_type   status;
   sftdb_pkg::req_payload_type req_payload;
   sftdb_pkg::rsp_payload_type rsp_payload;
   logic req_ready;
   logic rsp_valid;

   assign req_payload      = req_chan.payload;
   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_payload;

   sftdb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_payload.req_type),
      .req_last  (req_payload.last_table),
      .req_ready (req_ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   sftdb_dp #(
      .MAX_TABLES (MAX_TABLES),
      .SIZE_LIMIT (SIZE_LIMIT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> rtl/core/sftdb_ctrl.sv
// Controller state machine for the sfnt table directory builder.
// Issues datapath commands and owns the handshakes; uses sftdb_pkg.
module sftdb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_type,
   input  logic                    req_last,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   input  sftdb_pkg::dp_status_type status,
   output sftdb_pkg::ctl_cmd_type   cmd
);

   sftdb_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic info_take;
   logic word_take;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      req_ready = out_free &&
                  (state_ff == sftdb_pkg::ST_COLLECT || state_ff == sftdb_pkg::ST_DATA);
      info_take = req_valid && req_ready && (state_ff == sftdb_pkg::ST_COLLECT) && !req_type;
      word_take = req_valid && req_ready && (state_ff == sftdb_pkg::ST_DATA) && req_type;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sftdb_pkg::ST_COLLECT: begin
            if (info_take && req_last) state_in = sftdb_pkg::ST_HEADER;
         end
         sftdb_pkg::ST_HEADER: begin
            if (out_free) begin
               if (status.count_over || status.size_over) state_in = sftdb_pkg::ST_COLLECT;
               else state_in = sftdb_pkg::ST_FETCH;
            end
         end
         sftdb_pkg::ST_FETCH: begin
            state_in = sftdb_pkg::ST_DATA;
         end
         sftdb_pkg::ST_DATA: begin
            if (word_take && status.word_last) begin
               if (status.table_last) state_in = sftdb_pkg::ST_COLLECT;
               else state_in = sftdb_pkg::ST_FETCH;
            end
         end
         default: begin
            state_in = sftdb_pkg::ST_COLLECT;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.rsp_kind = sftdb_pkg::KIND_HEADER;
      case (state_ff)
         sftdb_pkg::ST_COLLECT: begin
            cmd.info_wr = info_take;
         end
         sftdb_pkg::ST_HEADER: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               if (status.count_over) begin
                  cmd.rsp_kind = sftdb_pkg::KIND_ERR_COUNT;
                  cmd.clear    = 1'b1;
               end else if (status.size_over) begin
                  cmd.rsp_kind = sftdb_pkg::KIND_ERR_SIZE;
                  cmd.clear    = 1'b1;
               end else begin
                  cmd.rsp_kind  = sftdb_pkg::KIND_HEADER;
                  cmd.hdr_start = 1'b1;
               end
            end
         end
         sftdb_pkg::ST_DATA: begin
            cmd.word_acc = word_take;
            if (word_take && status.word_last) begin
               cmd.entry_emit = 1'b1;
               cmd.rsp_load   = 1'b1;
               cmd.rsp_kind   = sftdb_pkg::KIND_ENTRY;
               cmd.clear      = status.table_last;
            end
         end
         default: begin
            cmd.clear = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sftdb_pkg::ST_COLLECT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/sftdb_dp.sv
// Datapath for the sfnt table directory builder: table store, size and count
// tracking, header math, checksum and offset accumulation. Uses sftdb_pkg.
module sftdb_dp #(
   parameter int MAX_TABLES = 64,
   parameter int SIZE_LIMIT = 67108864
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sftdb_pkg::ctl_cmd_type     cmd,
   input  sftdb_pkg::req_payload_type req_payload,
   output sftdb_pkg::dp_status_type   status,
   output sftdb_pkg::rsp_payload_type rsp_payload
);

   localparam int AW  = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
   localparam int CTW = $clog2(MAX_TABLES + 1);
   localparam int TSW = $clog2(MAX_TABLES + 2);
   localparam logic [27:0] LIMIT_28 = 28'(SIZE_LIMIT);

   // table store: tag in the upper 32 bits, length in the lower 27
   logic [58:0] table_mem [MAX_TABLES];
   logic [58:0] rd_data_ff;

   logic [TSW-1:0] tables_seen_ff, tables_seen_in;
   logic [26:0]    padded_sum_ff, padded_sum_in;
   logic           cff_seen_ff, cff_seen_in;
   logic [CTW-1:0] current_table_ff, current_table_in;
   logic [24:0]    words_done_ff, words_done_in;
   logic [31:0]    checksum_ff, checksum_in;
   logic [26:0]    offset_ff, offset_in;
   sftdb_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [27:0] len_pad;
   logic [27:0] pad_add;
   logic [27:0] sum_next;
   logic [16:0] hdr_bytes;
   logic [27:0] total_bytes;
   logic [3:0]  entry_sel;
   logic [31:0] count_x16;
   logic [31:0] range_x16;
   logic [31:0] rd_tag;
   logic [26:0] rd_len;
   logic [27:0] rd_len_pad;
   logic [24:0] words_need;
   logic [24:0] words_next;
   logic [31:0] checksum_next;
   logic [TSW-1:0] table_next;

   // collection-side size tracking, saturating just above the limit
   always_comb begin
      len_pad  = sftdb_pkg::pad4(req_payload.table_length[26:0]);
      pad_add  = (req_payload.table_length > 32'(SIZE_LIMIT)) ? LIMIT_28 + 28'd1 : len_pad;
      sum_next = {1'b0, padded_sum_ff} + pad_add;
   end

   // header figures
   always_comb begin
      hdr_bytes   = 17'd12 + (17'(tables_seen_ff) << 4);
      total_bytes = 28'(hdr_bytes) + {1'b0, padded_sum_ff};
      entry_sel   = '0;
      for (int i = 0; i < TSW; i++) begin
         if (tables_seen_ff[i]) entry_sel = 4'(i);
      end
      count_x16 = 32'(tables_seen_ff) << 4;
      range_x16 = 32'd16 << entry_sel;
   end

   // directory-side word counting
   always_comb begin
      rd_tag        = rd_data_ff[58:27];
      rd_len        = rd_data_ff[26:0];
      rd_len_pad    = sftdb_pkg::pad4(rd_len);
      words_need    = (rd_len == '0) ? 25'd1 : rd_len_pad[26:2];
      words_next    = words_done_ff + 25'd1;
      checksum_next = (rd_len == '0) ? checksum_ff : checksum_ff + req_payload.data_word;
      table_next    = TSW'(current_table_ff) + TSW'(1);
   end

   always_comb begin
      status.count_over = tables_seen_ff > TSW'(MAX_TABLES);
      status.size_over  = total_bytes > LIMIT_28;
      status.word_last  = words_next >= words_need;
      status.table_last = table_next >= tables_seen_ff;
   end

   always_comb begin
      tables_seen_in   = tables_seen_ff;
      padded_sum_in    = padded_sum_ff;
      cff_seen_in      = cff_seen_ff;
      current_table_in = current_table_ff;
      words_done_in    = words_done_ff;
      checksum_in      = checksum_ff;
      offset_in        = offset_ff;
      if (cmd.clear) begin
         tables_seen_in   = '0;
         padded_sum_in    = '0;
         cff_seen_in      = 1'b0;
         current_table_in = '0;
         words_done_in    = '0;
         checksum_in      = '0;
         offset_in        = '0;
      end else if (cmd.info_wr) begin
         if (tables_seen_ff <= TSW'(MAX_TABLES)) tables_seen_in = tables_seen_ff + TSW'(1);
         if (req_payload.table_tag == sftdb_pkg::TAG_CFF) cff_seen_in = 1'b1;
         padded_sum_in = (sum_next > LIMIT_28) ? 27'(LIMIT_28 + 28'd1) : sum_next[26:0];
      end else if (cmd.hdr_start) begin
         current_table_in = '0;
         words_done_in    = '0;
         checksum_in      = '0;
         offset_in        = 27'(hdr_bytes);
      end else if (cmd.entry_emit) begin
         current_table_in = current_table_ff + CTW'(1);
         words_done_in    = '0;
         checksum_in      = '0;
         offset_in        = offset_ff + rd_len_pad[26:0];
      end else if (cmd.word_acc) begin
         words_done_in = words_next;
         checksum_in   = checksum_next;
      end
   end

   always_comb begin
      rsp_in             = '0;
      rsp_in.result_kind = cmd.rsp_kind;
      case (cmd.rsp_kind)
         sftdb_pkg::KIND_HEADER: begin
            rsp_in.sfnt_version   = cff_seen_ff ? sftdb_pkg::TAG_OTTO : sftdb_pkg::VER_TRUETYPE;
            rsp_in.table_count    = 7'(tables_seen_ff);
            rsp_in.search_range   = range_x16[15:0];
            rsp_in.entry_selector = entry_sel;
            rsp_in.range_shift    = 16'(count_x16 - range_x16);
            rsp_in.total_size     = total_bytes[26:0];
         end
         sftdb_pkg::KIND_ENTRY: begin
            rsp_in.entry_tag      = rd_tag;
            rsp_in.entry_checksum = checksum_next;
            rsp_in.entry_offset   = offset_ff;
            rsp_in.entry_length   = rd_len;
         end
         default: begin
            rsp_in.result_kind = cmd.rsp_kind;
         end
      endcase
   end

   assign rsp_payload = rsp_ff;

   // store write and registered read of the current table
   always_ff @(posedge clock) begin
      if (cmd.info_wr && !cmd.clear && tables_seen_ff < TSW'(MAX_TABLES)) begin
         table_mem[tables_seen_ff[AW-1:0]] <=
            {req_payload.table_tag, req_payload.table_length[26:0]};
      end
      rd_data_ff <= table_mem[current_table_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tables_seen_ff   <= '0;
         padded_sum_ff    <= '0;
         cff_seen_ff      <= 1'b0;
         current_table_ff <= '0;
         words_done_ff    <= '0;
         checksum_ff      <= '0;
         offset_ff        <= '0;
      end else begin
         tables_seen_ff   <= tables_seen_in;
         padded_sum_ff    <= padded_sum_in;
         cff_seen_ff      <= cff_seen_in;
         current_table_ff <= current_table_in;
         words_done_ff    <= words_done_in;
         checksum_ff      <= checksum_in;
         offset_ff        <= offset_in;
      end
   end

endmodule

>>> rtl/core/sftdb_checker.sv
// Port-level checks for the sfnt table directory builder, bound to the top level.
// Uses sftdb_pkg payload types and result codes.
module sftdb_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input sftdb_pkg::req_payload_type req_payload,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input sftdb_pkg::rsp_payload_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transaction completed");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("response payload changed while stalled");

   // nothing is offered on the response side right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.result_kind == sftdb_pkg::KIND_ERR_COUNT ||
                    rsp_payload.result_kind == sftdb_pkg::KIND_ERR_SIZE)
      |-> rsp_payload.sfnt_version == '0 && rsp_payload.table_count == '0 &&
          rsp_payload.total_size == '0 && rsp_payload.entry_tag == '0 &&
          rsp_payload.entry_checksum == '0 && rsp_payload.entry_length == '0)
      else $error("error response carries nonzero fields");

   a_offset_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.result_kind == sftdb_pkg::KIND_ENTRY
      |-> rsp_payload.entry_offset[1:0] == 2'b00)
      else $error("directory entry offset not 4-byte aligned");

endmodule

bind sfnt_table_directory_builder_core sftdb_checker u_sftdb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_payload (req_chan.payload),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
